@@ hw/rtl/rkc_pkg.sv @@
// ----------------------------------------------------------------------------
// rkc_pkg
// Shared types and constants of the RGB k-means colour clustering block.
// ----------------------------------------------------------------------------
package rkc_pkg;

	localparam int MaxPixels   = 4096;
	localparam int MaxClusters = 16;
	localparam int PixIdxW     = 12;
	localparam int PixCntW     = 13;
	localparam int ClusterW    = 4;
	localparam int ChanW       = 8;
	localparam int SumW        = 20;
	localparam int CntW        = 13;

	typedef struct packed {
		logic [ChanW-1:0] r;
		logic [ChanW-1:0] g;
		logic [ChanW-1:0] b;
	} rgb_t;

	typedef enum logic [1:0] {
		FUNC_LOAD          = 2'd0,
		FUNC_RUN           = 2'd1,
		FUNC_READ_LABEL    = 2'd2,
		FUNC_READ_CENTROID = 2'd3
	} func_t;

	localparam logic [1:0] StatusOk    = 2'd0;
	localparam logic [1:0] StatusRange = 2'd1;
	localparam logic [1:0] StatusNoRun = 2'd2;

	localparam logic [1:0] CfgNumClusters = 2'd0;
	localparam logic [1:0] CfgImageWidth  = 2'd1;
	localparam logic [1:0] CfgImageHeight = 2'd2;
	localparam logic [1:0] CfgMaxPasses   = 2'd3;

endpackage

@@ hw/rtl/rkc_divider.sv @@
// ----------------------------------------------------------------------------
// rkc_divider
// Restoring divider, one quotient bit per cycle, for the centroid means.
// ----------------------------------------------------------------------------
module rkc_divider
	import rkc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [SumW-1:0]  dividend,
	input  logic [CntW-1:0]  divisor,
	output logic             done,
	output logic [ChanW-1:0] quotient
);

	localparam int StepW = $clog2(SumW + 1);

	logic             busy_q;
	logic             done_q;
	logic [StepW-1:0] cnt_q;
	logic [CntW-1:0]  rem_q;
	logic [CntW-1:0]  dvs_q;
	logic [SumW-1:0]  quo_q;
	logic [CntW:0]    trial;
	logic [CntW:0]    rem_next;
	logic             ge;

	assign trial    = {rem_q, quo_q[SumW-1]};
	assign ge       = trial >= {1'b0, dvs_q};
	assign rem_next = ge ? (trial - {1'b0, dvs_q}) : trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == StepW'(SumW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[SumW-2:0], ge};
			rem_q <= rem_next[CntW-1:0];
		end
	end

	// the mean of 8-bit samples never exceeds 8 bits
	assign done     = done_q;
	assign quotient = quo_q[ChanW-1:0];

endmodule

@@ hw/rtl/rgb_kmeans_color_clustering.sv @@
// ----------------------------------------------------------------------------
// rgb_kmeans_color_clustering
// K-means colour clustering of a stored RGB image with grid seeding.
// ----------------------------------------------------------------------------
// Loads, centroid reads and out-of-range or early reads are answered from the
// idle state and may follow back to back while the output is taken; a label
// read goes through ST_RD_LABEL for the label memory read. A run seeds the
// centroids (step search and grid walk, g = ceil(sqrt k)), then repeats passes
// of one centroid distance per cycle against the pixel memory read port,
// followed by mean division in three one-bit-a-cycle dividers and pass
// bookkeeping. The run result is given once the last pass ends; no item is
// taken meanwhile.
module rgb_kmeans_color_clustering
	import rkc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [7:0]         cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         func,
	input  logic [PixIdxW-1:0] index,
	input  logic [ChanW-1:0]   red,
	input  logic [ChanW-1:0]   green,
	input  logic [ChanW-1:0]   blue,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [ClusterW-1:0] label,
	output logic [ChanW-1:0]   out_red,
	output logic [ChanW-1:0]   out_green,
	output logic [ChanW-1:0]   out_blue,
	output logic               converged,
	output logic [1:0]         status
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_RD_LABEL, ST_SEED_G, ST_SEED_SX, ST_SEED_SY, ST_SEED_PT,
		ST_SEED_WAIT, ST_PASS_CLR, ST_PIX_RD, ST_DIST, ST_DIST_END, ST_ACC,
		ST_UPD_CHK, ST_UPD_WAIT, ST_PASS_END, ST_DONE
	} state_t;

	state_t state_q;

	logic [4:0] num_clusters_q;
	logic [6:0] image_width_q, image_height_q;
	logic [7:0] max_passes_q;

	logic [4:0]         k_eff;
	logic [6:0]         w_eff, h_eff;
	logic [13:0]        wh;
	logic [PixCntW-1:0] n_eff;
	logic [7:0]         cap;

	assign k_eff = (num_clusters_q == 5'd0) ? 5'd1 :
		(num_clusters_q > 5'(MaxClusters)) ? 5'(MaxClusters) : num_clusters_q;
	assign w_eff = (image_width_q == 7'd0) ? 7'd1 : image_width_q;
	assign h_eff = (image_height_q == 7'd0) ? 7'd1 : image_height_q;
	assign wh    = w_eff * h_eff;
	assign n_eff = (wh > 14'(MaxPixels)) ? PixCntW'(MaxPixels) : wh[PixCntW-1:0];
	assign cap   = (max_passes_q == 8'd0) ? 8'd1 : max_passes_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_clusters_q <= 5'd4;
			image_width_q  <= 7'd64;
			image_height_q <= 7'd64;
			max_passes_q   <= 8'd64;
		end else if (cfg_we) begin
			case (cfg_index)
				CfgNumClusters: num_clusters_q <= cfg_data[4:0];
				CfgImageWidth:  image_width_q  <= cfg_data[6:0];
				CfgImageHeight: image_height_q <= cfg_data[6:0];
				CfgMaxPasses:   max_passes_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// memories and cluster state
	rgb_t               pix_mem [MaxPixels];
	logic [ClusterW-1:0] lbl_mem [MaxPixels];
	rgb_t               px_rd_q;
	logic [ClusterW-1:0] lbl_rd_q;
	logic [PixIdxW-1:0] px_addr;

	rgb_t               cen_q [MaxClusters];
	logic [SumW-1:0]    sum_r_q [MaxClusters];
	logic [SumW-1:0]    sum_g_q [MaxClusters];
	logic [SumW-1:0]    sum_b_q [MaxClusters];
	logic [CntW-1:0]    cnt_q [MaxClusters];
	logic [ClusterW-1:0] cen_addr, sum_addr;
	rgb_t               cen_rd;

	// run control
	logic [2:0]         g_q, i_q, j_q;
	logic [13:0]        dd_q, syw_q;
	logic [6:0]         s_q, sx_q, sy_q;
	logic [14:0]        sq_q;
	logic [16:0]        row_q;
	logic [9:0]         col_q;
	logic [4:0]         found_q;
	logic [PixCntW-1:0] p_q;
	logic [4:0]         c_q;
	logic [ClusterW-1:0] best_q;
	logic [17:0]        best_d_q;
	logic               changed_q;
	logic [7:0]         pass_cnt_q;
	logic               run_done_q, last_conv_q;

	// distance pipe
	logic               v_s1;
	logic [ClusterW-1:0] c_s1;
	logic [15:0]        sqr_r_s1, sqr_g_s1, sqr_b_s1;
	logic [17:0]        sq_dist;

	// output register
	logic               out_valid_q;
	logic [ClusterW-1:0] out_label_q;
	rgb_t               out_rgb_q;
	logic               out_conv_q;
	logic [1:0]         out_status_q;

	logic accept, out_free;
	logic [19:0] sqk;
	logic [6:0]  dim, step_val;
	logic        step_go;
	logic [16:0] pt_idx;
	logic        div_start, div_done;
	logic        dr, dg, db;
	rgb_t        mean;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == ST_IDLE) && out_free;
	assign accept   = in_valid && in_ready;

	assign dim      = (state_q == ST_SEED_SY) ? h_eff : w_eff;
	assign sqk      = sq_q * k_eff;
	assign step_go  = (s_q < dim) && (sqk <= 20'(dd_q));
	assign step_val = (s_q == 7'd0) ? 7'd1 : s_q;
	assign pt_idx   = row_q + 17'(col_q);

	always_comb begin
		case (state_q)
			ST_SEED_PT:                      px_addr = pt_idx[PixIdxW-1:0];
			ST_PIX_RD, ST_DIST, ST_DIST_END,
			ST_ACC:                          px_addr = p_q[PixIdxW-1:0];
			default:                         px_addr = index;
		endcase
		case (state_q)
			ST_DIST, ST_UPD_CHK, ST_UPD_WAIT: cen_addr = c_q[ClusterW-1:0];
			ST_RD_LABEL:                      cen_addr = lbl_rd_q;
			default:                          cen_addr = index[ClusterW-1:0];
		endcase
		sum_addr = (state_q == ST_ACC) ? best_q : c_q[ClusterW-1:0];
	end

	assign cen_rd = cen_q[cen_addr];

	always_ff @(posedge clk) begin
		if (accept && func_t'(func) == FUNC_LOAD)
			pix_mem[index] <= '{r: red, g: green, b: blue};
		px_rd_q <= pix_mem[px_addr];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_ACC)
			lbl_mem[p_q[PixIdxW-1:0]] <= best_q;
		lbl_rd_q <= lbl_mem[index];
	end

	// centroid registers: clear at run start, seed, then update
	always_ff @(posedge clk) begin
		if (accept && func_t'(func) == FUNC_RUN) begin
			for (int c = 0; c < MaxClusters; c++)
				cen_q[c] <= '0;
		end else if (state_q == ST_SEED_WAIT) begin
			cen_q[found_q[ClusterW-1:0]] <= px_rd_q;
		end else if (state_q == ST_UPD_WAIT && div_done) begin
			cen_q[c_q[ClusterW-1:0]] <= mean;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_PASS_CLR) begin
			for (int c = 0; c < MaxClusters; c++) begin
				sum_r_q[c] <= '0;
				sum_g_q[c] <= '0;
				sum_b_q[c] <= '0;
				cnt_q[c]   <= '0;
			end
		end else if (state_q == ST_ACC) begin
			sum_r_q[sum_addr] <= sum_r_q[sum_addr] + SumW'(px_rd_q.r);
			sum_g_q[sum_addr] <= sum_g_q[sum_addr] + SumW'(px_rd_q.g);
			sum_b_q[sum_addr] <= sum_b_q[sum_addr] + SumW'(px_rd_q.b);
			cnt_q[sum_addr]   <= cnt_q[sum_addr] + 1'b1;
		end
	end

	// squared distance, squares registered before the sum and compare
	function automatic logic [ChanW-1:0] absdiff(logic [ChanW-1:0] a, logic [ChanW-1:0] b);
		return (a >= b) ? (a - b) : (b - a);
	endfunction

	always_ff @(posedge clk) begin
		c_s1     <= c_q[ClusterW-1:0];
		sqr_r_s1 <= absdiff(px_rd_q.r, cen_rd.r) * absdiff(px_rd_q.r, cen_rd.r);
		sqr_g_s1 <= absdiff(px_rd_q.g, cen_rd.g) * absdiff(px_rd_q.g, cen_rd.g);
		sqr_b_s1 <= absdiff(px_rd_q.b, cen_rd.b) * absdiff(px_rd_q.b, cen_rd.b);
	end

	assign sq_dist = 18'(sqr_r_s1) + 18'(sqr_g_s1) + 18'(sqr_b_s1);

	assign div_start = (state_q == ST_UPD_CHK) && (c_q < k_eff) &&
		(cnt_q[sum_addr] != '0);

	rkc_divider u_div_r (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(sum_r_q[sum_addr]),
		.divisor(cnt_q[sum_addr]), .done(dr), .quotient(mean.r)
	);
	rkc_divider u_div_g (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(sum_g_q[sum_addr]),
		.divisor(cnt_q[sum_addr]), .done(dg), .quotient(mean.g)
	);
	rkc_divider u_div_b (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(sum_b_q[sum_addr]),
		.divisor(cnt_q[sum_addr]), .done(db), .quotient(mean.b)
	);

	assign div_done = dr && dg && db;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			out_valid_q  <= 1'b0;
			run_done_q   <= 1'b0;
			last_conv_q  <= 1'b0;
			pass_cnt_q   <= '0;
			v_s1         <= 1'b0;
			g_q <= '0; i_q <= '0; j_q <= '0;
			s_q <= '0; sq_q <= '0; dd_q <= '0; sx_q <= '0; sy_q <= '0; syw_q <= '0;
			row_q <= '0; col_q <= '0; found_q <= '0;
			p_q <= '0; c_q <= '0; best_q <= '0; best_d_q <= '0; changed_q <= 1'b0;
			out_label_q  <= '0;
			out_rgb_q    <= '0;
			out_conv_q   <= 1'b0;
			out_status_q <= StatusOk;
		end else begin
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			v_s1 <= (state_q == ST_DIST);
			if (v_s1 && (c_s1 == '0 || sq_dist < best_d_q)) begin
				best_q   <= c_s1;
				best_d_q <= sq_dist;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						out_label_q  <= '0;
						out_rgb_q    <= '0;
						out_conv_q   <= last_conv_q;
						out_status_q <= StatusOk;
						out_valid_q  <= 1'b1;
						case (func_t'(func))
							FUNC_LOAD: ;
							FUNC_RUN: begin
								out_valid_q <= 1'b0;
								g_q         <= '0;
								pass_cnt_q  <= '0;
								state_q     <= ST_SEED_G;
							end
							FUNC_READ_LABEL: begin
								if (!run_done_q)
									out_status_q <= StatusNoRun;
								else if (13'(index) >= n_eff)
									out_status_q <= StatusRange;
								else begin
									out_valid_q <= 1'b0;
									state_q     <= ST_RD_LABEL;
								end
							end
							default: begin
								if (!run_done_q)
									out_status_q <= StatusNoRun;
								else if (index >= 12'(k_eff))
									out_status_q <= StatusRange;
								else
									out_rgb_q <= cen_rd;
							end
						endcase
					end
				end
				ST_RD_LABEL: begin
					out_label_q <= lbl_rd_q;
					out_rgb_q   <= cen_rd;
					out_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				ST_SEED_G: begin
					if (6'(g_q) * 6'(g_q) < 6'(k_eff))
						g_q <= g_q + 1'b1;
					else begin
						dd_q    <= w_eff * w_eff;
						s_q     <= '0;
						sq_q    <= 15'd1;
						state_q <= ST_SEED_SX;
					end
				end
				ST_SEED_SX, ST_SEED_SY: begin
					if (step_go) begin
						s_q  <= s_q + 1'b1;
						sq_q <= sq_q + {7'd0, s_q, 1'b0} + 15'd3;
					end else begin
						s_q  <= '0;
						sq_q <= 15'd1;
						if (state_q == ST_SEED_SX) begin
							sx_q    <= step_val;
							dd_q    <= h_eff * h_eff;
							state_q <= ST_SEED_SY;
						end else begin
							sy_q    <= step_val;
							syw_q   <= step_val * w_eff;
							i_q <= '0; j_q <= '0; row_q <= '0; col_q <= '0;
							found_q <= '0;
							state_q <= ST_SEED_PT;
						end
					end
				end
				ST_SEED_PT: begin
					if (i_q >= g_q || found_q >= k_eff)
						state_q <= ST_PASS_CLR;
					else begin
						if (pt_idx < 17'(n_eff))
							state_q <= ST_SEED_WAIT;
						// step j inner, i outer
						if (j_q + 1'b1 == g_q) begin
							j_q   <= '0;
							i_q   <= i_q + 1'b1;
							row_q <= '0;
							col_q <= col_q + 10'(sx_q);
						end else begin
							j_q   <= j_q + 1'b1;
							row_q <= row_q + 17'(syw_q);
						end
					end
				end
				ST_SEED_WAIT: begin
					found_q <= found_q + 1'b1;
					state_q <= ST_SEED_PT;
				end
				ST_PASS_CLR: begin
					changed_q <= 1'b0;
					p_q       <= '0;
					state_q   <= ST_PIX_RD;
				end
				ST_PIX_RD: begin
					c_q     <= '0;
					state_q <= ST_DIST;
				end
				ST_DIST: begin
					if (c_q + 1'b1 == k_eff)
						state_q <= ST_DIST_END;
					else
						c_q <= c_q + 1'b1;
				end
				ST_DIST_END: state_q <= ST_ACC;
				ST_ACC: begin
					p_q <= p_q + 1'b1;
					if (p_q + 1'b1 == n_eff) begin
						c_q     <= '0;
						state_q <= ST_UPD_CHK;
					end else
						state_q <= ST_PIX_RD;
				end
				ST_UPD_CHK: begin
					if (c_q >= k_eff)
						state_q <= ST_PASS_END;
					else if (div_start)
						state_q <= ST_UPD_WAIT;
					else
						c_q <= c_q + 1'b1;
				end
				ST_UPD_WAIT: begin
					if (div_done) begin
						if (mean != cen_rd)
							changed_q <= 1'b1;
						c_q     <= c_q + 1'b1;
						state_q <= ST_UPD_CHK;
					end
				end
				ST_PASS_END: begin
					pass_cnt_q <= pass_cnt_q + 1'b1;
					if (!changed_q || pass_cnt_q + 1'b1 == cap) begin
						last_conv_q <= !changed_q;
						state_q     <= ST_DONE;
					end else
						state_q <= ST_PASS_CLR;
				end
				ST_DONE: begin
					if (out_free) begin
						run_done_q   <= 1'b1;
						out_label_q  <= '0;
						out_rgb_q    <= '0;
						out_conv_q   <= last_conv_q;
						out_status_q <= StatusOk;
						out_valid_q  <= 1'b1;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign label     = out_label_q;
	assign out_red   = out_rgb_q.r;
	assign out_green = out_rgb_q.g;
	assign out_blue  = out_rgb_q.b;
	assign converged = out_conv_q;
	assign status    = out_status_q;

	a_pass_cap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PASS_END) |-> (pass_cnt_q < cap))
		else $error("pass count beyond cap");

	a_seed_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEED_WAIT) |-> (found_q < k_eff))
		else $error("seed beyond cluster count");

	a_div_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> $past(state_q == ST_UPD_WAIT))
		else $error("divider finished outside update");

	a_run_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && out_free) |=> run_done_q && out_valid_q)
		else $error("run finished without result");

endmodule
